FILE: hdl/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared constants, register codes and helpers for the camera projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned AXIS_WIDTH      = 48;
  localparam int unsigned COMP_WIDTH      = 16;
  localparam int unsigned ZOOM_WIDTH      = 31;
  localparam int unsigned CFG_IDX_WIDTH   = 3;
  localparam int unsigned FIFO_DEPTH      = 2;
  localparam int unsigned CHUNK_WIDTH     = 32;

  localparam logic [AXIS_WIDTH-1:0] RIGHT_AXIS_RST   = 48'h0000_0000_4000;
  localparam logic [AXIS_WIDTH-1:0] UP_AXIS_RST      = 48'h0000_4000_0000;
  localparam logic [AXIS_WIDTH-1:0] FORWARD_AXIS_RST = 48'h4000_0000_0000;
  localparam logic [ZOOM_WIDTH-1:0] ZOOM_RST         = 31'h0001_0000;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_VIEW_X       = 3'd0,
    REG_VIEW_Y       = 3'd1,
    REG_VIEW_Z       = 3'd2,
    REG_RIGHT_AXIS   = 3'd3,
    REG_UP_AXIS      = 3'd4,
    REG_FORWARD_AXIS = 3'd5,
    REG_ZOOM         = 3'd6
  } cfg_reg_e;

  function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/camera_perspective_projection_top.sv
// An accepted request passes the front pipeline, the middle queue, the back
//   pipeline and the output queue before its result reaches the result ports.
// Throughput: one request per cycle through the pipelined datapath, unless back-pressure raises full.
// Reset clears the pipelines and both queues and loads the default camera
//   (origin, identity axes, zoom 1.0).
// ----------------------------------------------------------------------------
// camera_perspective_projection_top
// Look-at camera projection of Q16.16 world points onto the film plane.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_perspective_projection_top #(
  parameter int unsigned COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF,
  parameter int unsigned CFG_DW = cpp_pkg::max_u(COORD_WIDTH, cpp_pkg::AXIS_WIDTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [COORD_WIDTH-1:0]            point_x_i,
  input  logic [COORD_WIDTH-1:0]            point_y_i,
  input  logic [COORD_WIDTH-1:0]            point_z_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [COORD_WIDTH-1:0]            screen_x_o,
  output logic [COORD_WIDTH-1:0]            screen_y_o,
  output logic                              depth_zero_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cpp_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0]                 cfg_data_i
);
  import cpp_pkg::*;

  localparam int unsigned SW    = COORD_WIDTH + 19;
  localparam int unsigned MID_W = 3 * SW + 1;
  localparam int unsigned OUT_W = 2 * COORD_WIDTH + 1;

  logic [COORD_WIDTH-1:0] view_x_q, view_y_q, view_z_q;
  logic [AXIS_WIDTH-1:0]  right_q, up_q, fwd_q;
  logic [ZOOM_WIDTH-1:0]  zoom_q;

  logic             fr_ready, fr_valid, fr_zero;
  logic [SW-1:0]    fr_cx, fr_cy, fr_cz;
  logic             mid_full, mid_empty, mid_pop;
  logic [MID_W-1:0] mid_out;
  logic             bk_ready, bk_valid, bk_zero;
  logic [COORD_WIDTH-1:0] bk_sx, bk_sy;
  logic             out_full;
  logic [OUT_W-1:0] out_data;

  assign cfg_ready_o = 1'b1;
  assign full        = !fr_ready;
  assign mid_pop     = !mid_empty && bk_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_x_q <= '0;
      view_y_q <= '0;
      view_z_q <= '0;
      right_q  <= RIGHT_AXIS_RST;
      up_q     <= UP_AXIS_RST;
      fwd_q    <= FORWARD_AXIS_RST;
      zoom_q   <= ZOOM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_VIEW_X:       view_x_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_VIEW_Y:       view_y_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_VIEW_Z:       view_z_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_RIGHT_AXIS:   right_q  <= cfg_data_i[AXIS_WIDTH-1:0];
        REG_UP_AXIS:      up_q     <= cfg_data_i[AXIS_WIDTH-1:0];
        REG_FORWARD_AXIS: fwd_q    <= cfg_data_i[AXIS_WIDTH-1:0];
        REG_ZOOM:         zoom_q   <= cfg_data_i[ZOOM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  cpp_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (push),
    .in_ready_o     (fr_ready),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .view_x_i       (view_x_q),
    .view_y_i       (view_y_q),
    .view_z_i       (view_z_q),
    .right_axis_i   (right_q),
    .up_axis_i      (up_q),
    .forward_axis_i (fwd_q),
    .out_valid_o    (fr_valid),
    .out_ready_i    (!mid_full),
    .cam_x_o        (fr_cx),
    .cam_y_o        (fr_cy),
    .cam_z_o        (fr_cz),
    .depth_zero_o   (fr_zero)
  );

  cpp_fifo #(
    .WIDTH(MID_W),
    .DEPTH(FIFO_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .full_o  (mid_full),
    .data_i  ({fr_zero, fr_cz, fr_cy, fr_cx}),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_out)
  );

  cpp_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (!mid_empty),
    .in_ready_o   (bk_ready),
    .cam_x_i      (mid_out[SW-1:0]),
    .cam_y_i      (mid_out[2*SW-1:SW]),
    .cam_z_i      (mid_out[3*SW-1:2*SW]),
    .depth_zero_i (mid_out[3*SW]),
    .zoom_i       (zoom_q),
    .out_valid_o  (bk_valid),
    .out_ready_i  (!out_full),
    .screen_x_o   (bk_sx),
    .screen_y_o   (bk_sy),
    .depth_zero_o (bk_zero)
  );

  cpp_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_valid),
    .full_o  (out_full),
    .data_i  ({bk_zero, bk_sy, bk_sx}),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_data)
  );

  assign screen_x_o   = out_data[COORD_WIDTH-1:0];
  assign screen_y_o   = out_data[2*COORD_WIDTH-1:COORD_WIDTH];
  assign depth_zero_o = out_data[2*COORD_WIDTH];

endmodule

`default_nettype wire

FILE: hdl/cpp_fifo.sv
// ----------------------------------------------------------------------------
// cpp_fifo
// Small register queue between pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = cpp_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cpp_front.sv
// ----------------------------------------------------------------------------
// cpp_front
// Viewpoint subtract and camera-axis dot products; flags zero depth.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_front #(
  parameter int unsigned COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [COORD_WIDTH-1:0]            point_x_i,
  input  logic [COORD_WIDTH-1:0]            point_y_i,
  input  logic [COORD_WIDTH-1:0]            point_z_i,
  input  logic [COORD_WIDTH-1:0]            view_x_i,
  input  logic [COORD_WIDTH-1:0]            view_y_i,
  input  logic [COORD_WIDTH-1:0]            view_z_i,
  input  logic [cpp_pkg::AXIS_WIDTH-1:0]    right_axis_i,
  input  logic [cpp_pkg::AXIS_WIDTH-1:0]    up_axis_i,
  input  logic [cpp_pkg::AXIS_WIDTH-1:0]    forward_axis_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [COORD_WIDTH+18:0]           cam_x_o,
  output logic [COORD_WIDTH+18:0]           cam_y_o,
  output logic [COORD_WIDTH+18:0]           cam_z_o,
  output logic                              depth_zero_o
);
  import cpp_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = DW + COMP_WIDTH;
  localparam int unsigned SW = PW + 2;

  logic                   en;
  logic                   s1_v_q, s2_v_q, s3_v_q;
  logic [COORD_WIDTH-1:0] pt [3];
  logic [COORD_WIDTH-1:0] vw [3];
  logic [AXIS_WIDTH-1:0]  ax [3];
  logic signed [DW-1:0]   dif_d [3];
  logic signed [DW-1:0]   dif_q [3];
  logic signed [PW-1:0]   prod_d [3][3];
  logic signed [PW-1:0]   prod_q [3][3];
  logic signed [SW-1:0]   sum_d [3];
  logic signed [SW-1:0]   sum_q [3];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign vw[0] = view_x_i;
  assign vw[1] = view_y_i;
  assign vw[2] = view_z_i;
  assign ax[0] = right_axis_i;
  assign ax[1] = up_axis_i;
  assign ax[2] = forward_axis_i;

  assign en           = !s3_v_q || out_ready_i;
  assign in_ready_o   = en;
  assign out_valid_o  = s3_v_q;
  assign cam_x_o      = sum_q[0];
  assign cam_y_o      = sum_q[1];
  assign cam_z_o      = sum_q[2];
  assign depth_zero_o = (sum_q[2] == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif_d[k] = signed'({pt[k][COORD_WIDTH-1], pt[k]}) - signed'({vw[k][COORD_WIDTH-1], vw[k]});
    end
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[a][k] = PW'(dif_q[k]) * PW'(signed'(ax[a][COMP_WIDTH*k +: COMP_WIDTH]));
      end
      sum_d[a] = SW'(prod_q[a][0]) + SW'(prod_q[a][1]) + SW'(prod_q[a][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dif_q  <= dif_d;
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cpp_back.sv
// ----------------------------------------------------------------------------
// cpp_back
// Zoom multiply, pipelined restoring divide by depth, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_back #(
  parameter int unsigned COORD_WIDTH = cpp_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [COORD_WIDTH+18:0]        cam_x_i,
  input  logic [COORD_WIDTH+18:0]        cam_y_i,
  input  logic [COORD_WIDTH+18:0]        cam_z_i,
  input  logic                           depth_zero_i,
  input  logic [cpp_pkg::ZOOM_WIDTH-1:0] zoom_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [COORD_WIDTH-1:0]         screen_x_o,
  output logic [COORD_WIDTH-1:0]         screen_y_o,
  output logic                           depth_zero_o
);
  import cpp_pkg::*;

  localparam int unsigned SW  = COORD_WIDTH + 19;
  localparam int unsigned MW  = SW;
  localparam int unsigned NW  = MW + ZOOM_WIDTH;
  localparam int unsigned NCH = (MW + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
  localparam int unsigned PPW = CHUNK_WIDTH + ZOOM_WIDTH;
  localparam int unsigned RW  = NW + COORD_WIDTH;
  localparam int unsigned NL  = COORD_WIDTH + 1;

  logic en;

  // magnitude stage
  logic          b0_v_q;
  logic [MW-1:0] b0_ax_q, b0_ay_q, b0_az_q;
  logic          b0_nx_q, b0_ny_q, b0_zr_q;

  // zoom product stage
  logic                   b1_v_q;
  logic [PPW-1:0]         ppx_d [NCH];
  logic [PPW-1:0]         ppy_d [NCH];
  logic [PPW-1:0]         ppx_q [NCH];
  logic [PPW-1:0]         ppy_q [NCH];
  logic [MW-1:0]          b1_az_q;
  logic                   b1_nx_q, b1_ny_q, b1_zr_q;
  logic [NCH*CHUNK_WIDTH-1:0] xpad, ypad;

  // divider levels
  logic                   lv_v_q [NL];
  logic [RW-1:0]          rx_d [NL];
  logic [RW-1:0]          rx_q [NL];
  logic [RW-1:0]          ry_d [NL];
  logic [RW-1:0]          ry_q [NL];
  logic [MW-1:0]          dv_d [NL];
  logic [MW-1:0]          dv_q [NL];
  logic [COORD_WIDTH-1:0] qx_d [NL];
  logic [COORD_WIDTH-1:0] qx_q [NL];
  logic [COORD_WIDTH-1:0] qy_d [NL];
  logic [COORD_WIDTH-1:0] qy_q [NL];
  logic                   ox_d [NL];
  logic                   ox_q [NL];
  logic                   oy_d [NL];
  logic                   oy_q [NL];
  logic                   nx_d [NL];
  logic                   nx_q [NL];
  logic                   ny_d [NL];
  logic                   ny_q [NL];
  logic                   zr_d [NL];
  logic                   zr_q [NL];

  function automatic logic [COORD_WIDTH-1:0] sat_sign(input logic [COORD_WIDTH-1:0] q,
                                                      input logic ovf, input logic neg);
    logic [COORD_WIDTH-1:0] lim;
    logic [COORD_WIDTH-1:0] r;
    lim = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
    if (!neg) begin
      lim = lim - COORD_WIDTH'(1);
    end
    r = (ovf || (q > lim)) ? lim : q;
    return neg ? (COORD_WIDTH'(0) - r) : r;
  endfunction

  assign en           = !lv_v_q[NL-1] || out_ready_i;
  assign in_ready_o   = en;
  assign out_valid_o  = lv_v_q[NL-1];
  assign depth_zero_o = zr_q[NL-1];
  assign screen_x_o   = zr_q[NL-1] ? '0 : sat_sign(qx_q[NL-1], ox_q[NL-1], nx_q[NL-1]);
  assign screen_y_o   = zr_q[NL-1] ? '0 : sat_sign(qy_q[NL-1], oy_q[NL-1], ny_q[NL-1]);

  assign xpad = (NCH*CHUNK_WIDTH)'(b0_ax_q);
  assign ypad = (NCH*CHUNK_WIDTH)'(b0_ay_q);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ppx_d[c] = PPW'(xpad[CHUNK_WIDTH*c +: CHUNK_WIDTH]) * PPW'(zoom_i);
      ppy_d[c] = PPW'(ypad[CHUNK_WIDTH*c +: CHUNK_WIDTH]) * PPW'(zoom_i);
    end
  end

  // level 0 loads the scaled numerators; then one quotient bit per level,
  // most significant first
  always_comb begin
    logic [RW-1:0] dsh;
    rx_d[0] = '0;
    ry_d[0] = '0;
    for (int c = 0; c < NCH; c++) begin
      rx_d[0] = rx_d[0] + (RW'(ppx_q[c]) << (CHUNK_WIDTH * c));
      ry_d[0] = ry_d[0] + (RW'(ppy_q[c]) << (CHUNK_WIDTH * c));
    end
    rx_d[0] = RW'(rx_d[0][NW-1:0]);
    ry_d[0] = RW'(ry_d[0][NW-1:0]);
    dv_d[0] = b1_az_q;
    qx_d[0] = '0;
    qy_d[0] = '0;
    ox_d[0] = 1'b0;
    oy_d[0] = 1'b0;
    nx_d[0] = b1_nx_q;
    ny_d[0] = b1_ny_q;
    zr_d[0] = b1_zr_q;
    for (int j = 0; j < COORD_WIDTH; j++) begin
      dsh       = RW'(dv_q[j]) << (COORD_WIDTH - 1 - j);
      dv_d[j+1] = dv_q[j];
      nx_d[j+1] = nx_q[j];
      ny_d[j+1] = ny_q[j];
      zr_d[j+1] = zr_q[j];
      if (j == 0) begin
        ox_d[j+1] = (rx_q[j] >> COORD_WIDTH) >= RW'(dv_q[j]);
        oy_d[j+1] = (ry_q[j] >> COORD_WIDTH) >= RW'(dv_q[j]);
      end else begin
        ox_d[j+1] = ox_q[j];
        oy_d[j+1] = oy_q[j];
      end
      rx_d[j+1] = rx_q[j];
      qx_d[j+1] = qx_q[j];
      if (rx_q[j] >= dsh) begin
        rx_d[j+1] = rx_q[j] - dsh;
        qx_d[j+1][COORD_WIDTH-1-j] = 1'b1;
      end
      ry_d[j+1] = ry_q[j];
      qy_d[j+1] = qy_q[j];
      if (ry_q[j] >= dsh) begin
        ry_d[j+1] = ry_q[j] - dsh;
        qy_d[j+1][COORD_WIDTH-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
      b1_v_q <= 1'b0;
      for (int l = 0; l < NL; l++) begin
        lv_v_q[l] <= 1'b0;
      end
    end else if (en) begin
      b0_v_q    <= in_valid_i;
      b1_v_q    <= b0_v_q;
      lv_v_q[0] <= b1_v_q;
      for (int l = 1; l < NL; l++) begin
        lv_v_q[l] <= lv_v_q[l-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_ax_q <= cam_x_i[SW-1] ? MW'(-cam_x_i) : MW'(cam_x_i);
      b0_ay_q <= cam_y_i[SW-1] ? MW'(-cam_y_i) : MW'(cam_y_i);
      b0_az_q <= cam_z_i[SW-1] ? MW'(-cam_z_i) : MW'(cam_z_i);
      b0_nx_q <= cam_x_i[SW-1] ^ cam_z_i[SW-1];
      b0_ny_q <= cam_y_i[SW-1] ^ cam_z_i[SW-1];
      b0_zr_q <= depth_zero_i;
      ppx_q   <= ppx_d;
      ppy_q   <= ppy_d;
      b1_az_q <= b0_az_q;
      b1_nx_q <= b0_nx_q;
      b1_ny_q <= b0_ny_q;
      b1_zr_q <= b0_zr_q;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
      dv_q    <= dv_d;
      qx_q    <= qx_d;
      qy_q    <= qy_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      zr_q    <= zr_d;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/camera_perspective_projection_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_perspective_projection_top_tb
// Self-checking bench for the camera projection block: a built-in predictor
// computes screen x/y and the zero-depth flag for every accepted point, a
// checker compares each popped result. Directed corners, several camera
// settings with random points, and a back-pressure phase that fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_perspective_projection_top_tb;
  import cpp_pkg::*;

  localparam int unsigned CW = 32;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic          dz;
  } proj_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [CW-1:0] point_x_i = '0;
  logic [CW-1:0] point_y_i = '0;
  logic [CW-1:0] point_z_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CW-1:0] screen_x_o;
  logic [CW-1:0] screen_y_o;
  logic depth_zero_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i = '0;
  logic [AXIS_WIDTH-1:0] cfg_data_i = '0;

  camera_perspective_projection_top dut (.*);

  always #5 clk_i = ~clk_i;

  // camera copy
  logic signed [CW-1:0] cam_vx, cam_vy, cam_vz;
  logic [AXIS_WIDTH-1:0] cam_right, cam_up, cam_fwd;
  logic [ZOOM_WIDTH-1:0] cam_zoom;

  proj_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int cfg_writes = 0;
  bit no_idle = 0;
  int pop_hold = 0;

  function automatic logic signed [127:0] axis_dot(logic [AXIS_WIDTH-1:0] ax,
      logic signed [127:0] dx, logic signed [127:0] dy, logic signed [127:0] dz);
    logic signed [15:0] c0, c1, c2;
    c0 = ax[15:0];
    c1 = ax[31:16];
    c2 = ax[47:32];
    return dx * c0 + dy * c1 + dz * c2;
  endfunction

  function automatic logic [CW-1:0] scale_div(logic signed [127:0] num,
      logic signed [127:0] den);
    logic [127:0] n, d, q, lim;
    logic nn, dn;
    nn = num[127];
    dn = den[127];
    n = nn ? -num : num;
    d = dn ? -den : den;
    n = n * {97'd0, cam_zoom};
    q = n / d;
    lim = (128'd1 << (CW - 1)) - ((nn == dn) ? 128'd1 : 128'd0);
    if (q > lim) q = lim;
    if (nn != dn) q = -q;
    return q[CW-1:0];
  endfunction

  function automatic proj_t project_point(logic signed [CW-1:0] px,
      logic signed [CW-1:0] py, logic signed [CW-1:0] pz);
    logic signed [127:0] dx, dy, dz, cx, cy, cz;
    proj_t r;
    dx = px - cam_vx;
    dy = py - cam_vy;
    dz = pz - cam_vz;
    cx = axis_dot(cam_right, dx, dy, dz);
    cy = axis_dot(cam_up, dx, dy, dz);
    cz = axis_dot(cam_fwd, dx, dy, dz);
    if (cz == 0) begin
      r = '{sx: '0, sy: '0, dz: 1'b1};
    end else begin
      r = '{sx: scale_div(cx, cz), sy: scale_div(cy, cz), dz: 1'b0};
    end
    return r;
  endfunction

  function automatic void camera_defaults();
    cam_vx = '0; cam_vy = '0; cam_vz = '0;
    cam_right = RIGHT_AXIS_RST;
    cam_up = UP_AXIS_RST;
    cam_fwd = FORWARD_AXIS_RST;
    cam_zoom = ZOOM_RST;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    proj_t e;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h dz=%b",
                                       screen_x_o, screen_y_o, depth_zero_o);
      end else begin
        e = expected_q.pop_front();
        if (e.sx !== screen_x_o || e.sy !== screen_y_o || e.dz !== depth_zero_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h dz=%b got x=%h y=%h dz=%b",
                     e.sx, e.sy, e.dz, screen_x_o, screen_y_o, depth_zero_o);
        end
      end
    end
  end

  // result drain with random stalls
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = no_idle ? 0 : $urandom_range(0, 12);
      g += pop_hold;
      pop_hold = 0;
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    int g;
    g = no_idle ? 0 : $urandom_range(0, 12);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_q.push_back(project_point(x, y, z));
    requests_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (CW + 12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [AXIS_WIDTH-1:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_VIEW_X:       cam_vx = val[CW-1:0];
      REG_VIEW_Y:       cam_vy = val[CW-1:0];
      REG_VIEW_Z:       cam_vz = val[CW-1:0];
      REG_RIGHT_AXIS:   cam_right = val;
      REG_UP_AXIS:      cam_up = val;
      REG_FORWARD_AXIS: cam_fwd = val;
      REG_ZOOM:         cam_zoom = val[ZOOM_WIDTH-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CW-1:0] rand_coord(logic [CW-1:0] near);
    logic [CW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: v = near;
      3: v = near + $urandom_range(0, 255) - 128;
      default: v = near + {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
    endcase
    return v;
  endfunction

  task automatic random_points(int n);
    repeat (n) send_point(rand_coord(cam_vx), rand_coord(cam_vy), rand_coord(cam_vz));
  endtask

  function automatic logic [AXIS_WIDTH-1:0] rand_axis();
    logic [AXIS_WIDTH-1:0] a;
    a = {16'($urandom), $urandom};
    if ($urandom_range(0, 3) == 0) a[15:0] = 16'h8000;
    if ($urandom_range(0, 3) == 0) a[31:16] = 16'h7FFF;
    if ($urandom_range(0, 3) == 0) a[47:32] = 16'h0000;
    return a;
  endfunction

  task automatic test_directed();
    send_point(0, 0, 0);
    send_point(0, 0, 32'h0001_0000);
    send_point(32'h0002_0000, 32'hFFFD_0000, 32'h0001_0000);
    send_point(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0007);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0000_8000);
  endtask

  task automatic test_camera(logic [CW-1:0] vx, logic [CW-1:0] vy, logic [CW-1:0] vz,
      logic [AXIS_WIDTH-1:0] r, logic [AXIS_WIDTH-1:0] u, logic [AXIS_WIDTH-1:0] f,
      logic [ZOOM_WIDTH-1:0] zm, int n);
    write_reg(REG_VIEW_X, {16'd0, vx});
    write_reg(REG_VIEW_Y, {16'd0, vy});
    write_reg(REG_VIEW_Z, {16'd0, vz});
    write_reg(REG_RIGHT_AXIS, r);
    write_reg(REG_UP_AXIS, u);
    write_reg(REG_FORWARD_AXIS, f);
    write_reg(REG_ZOOM, {17'd0, zm});
    random_points(n);
  endtask

  task automatic test_backpressure();
    wait_drained();
    pop_hold = 300;
    no_idle = 1;
    random_points(80);
    no_idle = 0;
    wait_drained();
    no_idle = 1;
    random_points(100);
    no_idle = 0;
  endtask

  task automatic test_unused_index();
    write_reg(REG_UNUSED, {AXIS_WIDTH{1'b1}});
    random_points(20);
  endtask

  initial begin
    camera_defaults();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    random_points(100);
    test_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, RIGHT_AXIS_RST, UP_AXIS_RST,
                FORWARD_AXIS_RST, 31'h7FFF_FFFF, 140);
    test_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 48'h8000_8000_8000,
                48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_0001, 31'h0, 100);
    test_camera($urandom, $urandom, $urandom, rand_axis(), rand_axis(), rand_axis(),
                31'($urandom), 150);
    test_camera(32'h0001_0000, 32'hFFFE_0000, 32'h0003_8000, 48'h0000_0000_2D41,
                48'h0000_2D41_0000, 48'h2D41_0000_2D41, 31'h0004_0000, 150);
    test_camera($urandom, $urandom, $urandom, rand_axis(), rand_axis(), rand_axis(),
                31'($urandom_range(1, 32'h0010_0000)), 150);
    test_backpressure();
    test_unused_index();
    test_camera(0, 0, 0, {AXIS_WIDTH{1'b1}}, {AXIS_WIDTH{1'b0}}, {AXIS_WIDTH{1'b1}},
                31'h0000_0001, 150);
    test_camera(0, 0, 0, RIGHT_AXIS_RST, UP_AXIS_RST, FORWARD_AXIS_RST, ZOOM_RST, 150);
    wait_drained();
    $display("Covered %0d points over %0d register writes, %0d results checked,",
             requests_sent, cfg_writes, results_seen);
    $display("including zero depth, saturation, extreme cameras and a full stall.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/cpp_pkg.sv
hdl/cpp_fifo.sv
hdl/cpp_front.sv
hdl/cpp_back.sv
hdl/camera_perspective_projection_top.sv
tb/sv/camera_perspective_projection_top_tb.sv
